[rtl/bth_pkg.sv]
// Shared types and constants for the BER TLV header parser.
// No dependencies; imported by every module of the block.
package bth_pkg;

	// Field size limits
	localparam int MAX_LENGTH_OCTETS = 4;
	localparam int MAX_TAG_OCTETS    = 4;

	// Identifier and length octet fields
	localparam logic [4:0] TAG_EXTENDED   = 5'h1F;
	localparam logic [7:0] LEN_INDEFINITE = 8'h80;

	// Result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TRUNCATED  = 3'd1;
	localparam logic [2:0] ST_INDEFINITE = 3'd2;
	localparam logic [2:0] ST_LEN_LONG   = 3'd3;
	localparam logic [2:0] ST_TAG_LONG   = 3'd4;

	// Saturation point of the header octet count
	localparam logic [3:0] HDR_COUNT_MAX = 4'd15;

	// Depth of the result queue
	localparam logic [1:0] RESQ_DEPTH = 2'd2;

	// One result record
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  tag_class;
		logic        constructed;
		logic [27:0] tag_number;
		logic [31:0] content_length;
		logic [3:0]  header_length;
		logic        last_result;
	} result_t;

	// Results raised by one byte, first one first
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

[rtl/bth_step.sv]
// Per-byte decode step: parser state registers and the next-state / result logic.
// Depends on bth_pkg.
module bth_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      data_byte,
	input  logic            last_of_buffer,
	output bth_pkg::push_t  push
);
	import bth_pkg::*;

	typedef enum logic [2:0] {
		PH_IDENT   = 3'd0,
		PH_TAG     = 3'd1,
		PH_LEN0    = 3'd2,
		PH_LENN    = 3'd3,
		PH_CONTENT = 3'd4,
		PH_DISCARD = 3'd5
	} phase_t;

	localparam logic [2:0] TAG_LEFT_INIT = 3'(MAX_TAG_OCTETS - 1);
	localparam logic [6:0] LEN_OCT_MAX   = 7'(MAX_LENGTH_OCTETS);

	phase_t      phase_q, phase_n;
	logic [27:0] tag_q, tag_n;
	logic [31:0] len_q, len_n;
	logic [2:0]  left_q, left_n;
	logic [3:0]  hcnt_q, hcnt_n;
	logic [1:0]  cls_q, cls_n;
	logic        cons_q, cons_n;
	logic [31:0] cleft_q, cleft_n;

	logic        done;
	logic [2:0]  err;
	logic        trunc_content;
	logic [2:0]  len_oct_m1;
	logic [31:0] cleft_dec;
	result_t     base;

	// only reached with a length octet count of 1 to MAX_LENGTH_OCTETS
	assign len_oct_m1 = data_byte[2:0] - 3'd1;

	// content octets still owed once this byte is skipped
	assign cleft_dec = (cleft_q != 32'd0) ? cleft_q - 32'd1 : 32'd0;

	// Next state for the byte in hand
	always_comb begin
		phase_n       = phase_q;
		tag_n         = tag_q;
		len_n         = len_q;
		left_n        = left_q;
		hcnt_n        = hcnt_q;
		cls_n         = cls_q;
		cons_n        = cons_q;
		cleft_n       = cleft_q;
		done          = 1'b0;
		err           = ST_OK;
		trunc_content = 1'b0;

		// header octet count, saturating
		if ((phase_q == PH_IDENT || phase_q == PH_TAG || phase_q == PH_LEN0 ||
		     phase_q == PH_LENN) && hcnt_q != HDR_COUNT_MAX)
			hcnt_n = hcnt_q + 4'd1;

		unique case (phase_q)
			PH_IDENT: begin
				hcnt_n = 4'd1;
				cls_n  = data_byte[7:6];
				cons_n = data_byte[5];
				len_n  = '0;
				if (data_byte[4:0] == TAG_EXTENDED) begin
					tag_n   = '0;
					left_n  = TAG_LEFT_INIT;
					phase_n = PH_TAG;
				end else begin
					tag_n   = {23'd0, data_byte[4:0]};
					phase_n = PH_LEN0;
				end
			end
			PH_TAG: begin
				tag_n = {tag_q[20:0], data_byte[6:0]};
				if (!data_byte[7])
					phase_n = PH_LEN0;
				else if (left_q == 3'd0)
					err = ST_TAG_LONG;
				else
					left_n = left_q - 3'd1;
			end
			PH_LEN0: begin
				if (!data_byte[7]) begin
					len_n = {24'd0, data_byte};
					done  = 1'b1;
				end else if (data_byte == LEN_INDEFINITE) begin
					err = ST_INDEFINITE;
				end else if (data_byte[6:0] > LEN_OCT_MAX) begin
					err = ST_LEN_LONG;
				end else begin
					len_n   = '0;
					left_n  = len_oct_m1;
					phase_n = PH_LENN;
				end
			end
			PH_LENN: begin
				len_n = {len_q[23:0], data_byte};
				if (left_q == 3'd0)
					done = 1'b1;
				else
					left_n = left_q - 3'd1;
			end
			PH_CONTENT: begin
				cleft_n = cleft_dec;
				if (cleft_dec == 32'd0)
					phase_n = PH_IDENT;
				else if (last_of_buffer)
					trunc_content = 1'b1;
			end
			default: begin
			end
		endcase

		// header finished or failed
		if (done) begin
			cleft_n = len_n;
			phase_n = (len_n == 32'd0) ? PH_IDENT : PH_CONTENT;
		end else if (err != ST_OK) begin
			phase_n = PH_DISCARD;
		end

		// end of buffer resets the walk
		if (last_of_buffer) begin
			phase_n = PH_IDENT;
			cleft_n = '0;
			left_n  = '0;
		end
	end

	// Results for the byte in hand
	always_comb begin
		base = '{status: ST_OK, tag_class: cls_n, constructed: cons_n, tag_number: tag_n,
		         content_length: 32'd0, header_length: hcnt_n, last_result: 1'b1};
		push.count = 2'd0;
		push.r0    = base;
		push.r1    = base;
		push.r1.status = ST_TRUNCATED;
		push.r1.content_length = len_n;
		if (done) begin
			push.r0.content_length = len_n;
			if (last_of_buffer && len_n != 32'd0) begin
				push.count = 2'd2;
				push.r0.last_result = 1'b0;
			end else begin
				push.count = 2'd1;
			end
		end else if (err != ST_OK) begin
			push.count = 2'd1;
			push.r0.status = err;
		end else if (trunc_content) begin
			push.count = 2'd1;
			push.r0.status = ST_TRUNCATED;
			push.r0.content_length = cleft_dec;
		end else if (last_of_buffer &&
		             (phase_q == PH_IDENT || phase_q == PH_TAG || phase_q == PH_LEN0 ||
		              phase_q == PH_LENN)) begin
			// buffer ends inside a header
			push.count = 2'd1;
			push.r0.status = ST_TRUNCATED;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDENT;
			tag_q   <= '0;
			len_q   <= '0;
			left_q  <= '0;
			hcnt_q  <= '0;
			cls_q   <= '0;
			cons_q  <= 1'b0;
			cleft_q <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			tag_q   <= tag_n;
			len_q   <= len_n;
			left_q  <= left_n;
			hcnt_q  <= hcnt_n;
			cls_q   <= cls_n;
			cons_q  <= cons_n;
			cleft_q <= cleft_n;
		end
	end

`ifndef SYNTH
	// the last byte of a buffer always leaves the walker at an identifier
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_of_buffer |=> phase_q == PH_IDENT && cleft_q == 32'd0)
		else $error("walker not reset after end of buffer");

	// content skipping only runs with octets still to skip
	a_content_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CONTENT |-> cleft_q != 32'd0)
		else $error("content phase with nothing left to skip");
`endif

endmodule

[rtl/bth_resq.sv]
// Two-entry result queue between the decode step and the result port.
// Depends on bth_pkg.
module bth_resq (
	input  logic             clk,
	input  logic             arst_n,
	input  bth_pkg::push_t   push,
	input  logic             push_en,
	input  logic             pop_ready,
	output logic             head_valid,
	output bth_pkg::result_t head,
	output logic [1:0]       count
);
	import bth_pkg::*;

	result_t    slot0_q, slot1_q, slot0_n, slot1_n;
	logic [1:0] count_q, count_n, count_pop, push_n;
	logic       pop;

	assign head_valid = count_q != 2'd0;
	assign head       = slot0_q;
	assign count      = count_q;
	assign pop        = head_valid && pop_ready;
	assign push_n     = push_en ? push.count : 2'd0;
	assign count_pop  = count_q - {1'b0, pop};

	// Shift on transfer, then append new results behind what remains
	always_comb begin
		slot0_n = slot0_q;
		slot1_n = slot1_q;
		if (pop)
			slot0_n = slot1_q;
		if (push_n != 2'd0) begin
			if (count_pop == 2'd0)
				slot0_n = push.r0;
			else
				slot1_n = push.r0;
		end
		if (push_n == RESQ_DEPTH)
			slot1_n = push.r1;
		count_n = count_pop + push_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_n;
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_n;
		slot1_q <= slot1_n;
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue overflow");

	// a pair is only pushed into an empty queue
	a_pair_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push_en && push.count == RESQ_DEPTH |-> count_q == 2'd0)
		else $error("result pair pushed into occupied queue");

	// a result not marked last always has its partner queued behind it
	a_pair_kept: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !head.last_result |-> count_q == RESQ_DEPTH)
		else $error("first of a result pair without its partner");
`endif

endmodule

[rtl/ber_tlv_header_parser.sv]
// Top level of the BER TLV header parser: input register, decode step, result queue.
// Depends on bth_pkg, bth_step and bth_resq.
//
// Walks the top-level TLVs of a BER buffer fed one byte per transfer, with
// last_of_buffer on the final byte. Each completed header is reported with
// status 0 (class, constructed bit, tag number, content length, header octet
// count), and its content octets are then skipped silently. Errors (truncated
// buffer, indefinite length, too many length or tag octets) are reported once,
// after which input is dropped up to the end of the buffer. A byte enters an
// input register, is decoded combinationally against the parser state, and its
// results are registered in a two-entry queue that drives the result port. The
// block takes one byte per cycle while the result side keeps up; a header that
// completes on the last byte of a buffer with nonzero length raises two results
// and waits in the input register until the queue can take them, since the
// two-entry result queue must be empty to take the pair.
module ber_tlv_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_of_buffer,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  status,
	output logic [1:0]  tag_class,
	output logic        constructed,
	output logic [27:0] tag_number,
	output logic [31:0] content_length,
	output logic [3:0]  header_length,
	output logic        last_result
);
	import bth_pkg::*;

	logic       item_valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       fire;
	logic [2:0] fill_sum;
	logic [1:0] q_count;
	push_t      push;
	result_t    head;

	// Decode fires when the queue has room for every result of this byte
	assign fill_sum   = {1'b0, q_count} + {1'b0, push.count};
	assign fire       = item_valid_s1 && (push.count == 2'd0 || fill_sum <= {1'b0, RESQ_DEPTH});
	assign data_ready = !item_valid_s1 || fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_valid_s1 <= 1'b0;
		else if (data_ready)
			item_valid_s1 <= data_valid;
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_of_buffer;
		end
	end

	bth_step u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.data_byte      (byte_s1),
		.last_of_buffer (last_s1),
		.push           (push)
	);

	bth_resq u_resq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_en    (fire),
		.pop_ready  (result_ready),
		.head_valid (result_valid),
		.head       (head),
		.count      (q_count)
	);

	// Result fields
	assign status         = head.status;
	assign tag_class      = head.tag_class;
	assign constructed    = head.constructed;
	assign tag_number     = head.tag_number;
	assign content_length = head.content_length;
	assign header_length  = head.header_length;
	assign last_result    = head.last_result;

endmodule
